// File: rtl/emst_pkg.sv
// Package with the shared constants and item types of the spanning tree unit.
`timescale 1ns / 1ps
`default_nettype none
package emst_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;
    localparam int AW         = $clog2(MAX_POINTS);
    localparam int CNT_W      = AW + 1;
    localparam int LEN_W      = COORD_BITS + 17;
    localparam int BEST_W     = LEN_W + 1;
    localparam int SUM_W      = 47;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_LINK    = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  point_index;
        logic [19:0] point_x;
        logic [19:0] point_y;
        logic [9:0]  link_end_a;
        logic [9:0]  link_end_b;
        logic [10:0] point_count;
    } t_in_item;

    typedef struct packed {
        logic [46:0] total_length;
        logic        saturated;
    } t_out_item;
endpackage
`default_nettype wire

// File: rtl/emst_ifs.sv
// Valid/ready channel interfaces for input and result items.
`timescale 1ns / 1ps
`default_nettype none
interface emst_in_if;
    import emst_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface emst_out_if;
    import emst_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/emst_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module emst_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_wa,
    input  wire logic [W-1:0]         i_wd,
    input  wire logic [$clog2(D)-1:0] i_ra,
    output logic      [W-1:0]         o_rd
);
    logic [W-1:0] r_mem [D];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end
endmodule
`default_nettype wire

// File: rtl/emst_dist.sv
// Fixed point Euclidean distance: shared squarer, then one root digit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module emst_dist (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [emst_pkg::COORD_BITS-1:0]    i_xa,
    input  wire logic [emst_pkg::COORD_BITS-1:0]    i_xb,
    input  wire logic [emst_pkg::COORD_BITS-1:0]    i_ya,
    input  wire logic [emst_pkg::COORD_BITS-1:0]    i_yb,
    output logic                                    o_done,
    output logic      [emst_pkg::LEN_W-1:0]         o_len
);
    import emst_pkg::*;

    localparam int D2_W  = 2 * COORD_BITS + 1;
    localparam int SH_W  = 2 * COORD_BITS + 2;
    localparam int REM_W = LEN_W + 3;
    localparam int STEPS = LEN_W;
    localparam int SC_W  = $clog2(STEPS);

    typedef enum logic [1:0] {S_IDLE, S_SQX, S_SQY, S_ROOT} t_state;

    t_state                  r_state;
    logic [COORD_BITS-1:0]   r_dx, r_dy;
    logic [D2_W-1:0]         r_acc;
    logic [SH_W-1:0]         r_sh;
    logic [REM_W-1:0]        r_rem;
    logic [LEN_W-1:0]        r_root;
    logic [SC_W-1:0]         r_cnt;
    logic [COORD_BITS-1:0]   w_op;
    logic [2*COORD_BITS-1:0] w_sq;
    logic [REM_W-1:0]        w_rem2, w_trial;

    // One squarer shared by both axes.
    assign w_op = (r_state == S_SQX) ? r_dx : r_dy;
    assign w_sq = w_op * w_op;

    // Restoring square root digit step.
    assign w_rem2  = {r_rem[REM_W-3:0], r_sh[SH_W-1 -: 2]};
    assign w_trial = {{(REM_W-LEN_W-2){1'b0}}, r_root, 2'b01};
    assign o_len   = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            // Done pulses on the cycle after the last root digit.
            o_done <= (r_state == S_ROOT) && (r_cnt == '0);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_dx    <= (i_xa > i_xb) ? i_xa - i_xb : i_xb - i_xa;
                        r_dy    <= (i_ya > i_yb) ? i_ya - i_yb : i_yb - i_ya;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: begin
                    r_acc   <= {1'b0, w_sq};
                    r_state <= S_SQY;
                end
                S_SQY: begin
                    r_sh    <= {1'b0, r_acc + {1'b0, w_sq}};
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= SC_W'(STEPS - 1);
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_sh <= {r_sh[SH_W-3:0], 2'b00};
                    if (w_rem2 >= w_trial) begin
                        r_rem  <= w_rem2 - w_trial;
                        r_root <= {r_root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= w_rem2;
                        r_root <= {r_root[LEN_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/euclidean_mst_with_links_unit.sv
// Top level of the Euclidean spanning tree unit with existing links.
`timescale 1ns / 1ps
`default_nettype none
// Load items (command 0) and link items (command 1) are stored; a compute item
// (command 2) runs Prim's algorithm over the first point_count points and
// returns one result item. A link walks the group parent memory to both
// roots. A compute first finds the group root of each of its N points, then
// runs N update passes over all N points: a point already in the tree or in
// the group of the new member is passed over without a distance, and any
// other point waits for a distance evaluation by the shared squarer and the
// one-digit-per-cycle root unit. Each tree step adds a minimum search over all
// N points. After reset and after every compute a clearing pass over all 1024
// entries restores the group memory, during which no item is accepted. A
// compute whose result finds the previous result still waiting holds until
// that one is taken.
module euclidean_mst_with_links_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    emst_in_if.sink     i_in,
    emst_out_if.source  o_out
);
    import emst_pkg::*;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FRD, S_FEV, S_PRD, S_PLT, S_URD, S_UEV, S_UWT,
        S_UCMP, S_SRD, S_SEV, S_SPK, S_P0, S_DONE
    } t_state;

    typedef enum logic [1:0] {F_LA, F_LB, F_INIT} t_ctx;

    t_state              r_state;
    t_ctx                r_ctx;
    logic [AW-1:0]       r_idx, r_fp, r_ra, r_lb, r_pick;
    logic [CNT_W-1:0]    r_n, r_k;
    logic                r_cmp, r_have;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [AW-1:0]       r_proot;
    logic [BEST_W-1:0]   r_bcur, r_bbest, r_w;
    logic [SUM_W-1:0]    r_sum;
    logic                r_sat;
    logic                r_ovalid;
    t_out_item           r_out;

    logic [COORD_BITS-1:0] w_xd, w_yd;
    logic [AW-1:0]       w_pd, w_rd;
    logic [BEST_W-1:0]   w_bd;
    logic                w_td;
    logic                w_acc, w_last, w_dstart, w_ddone;
    logic [LEN_W-1:0]    w_dlen;
    logic [AW-1:0]       w_ra;
    logic                w_xy_we, w_p_we, w_r_we, w_b_we, w_t_we;
    logic [AW-1:0]       w_xy_wa, w_p_wa, w_b_wa, w_t_wa, w_p_wd;
    logic [BEST_W-1:0]   w_b_wd;
    logic                w_t_wd;
    logic [CNT_W-1:0]    w_cnt;

    assign i_in.ready    = (r_state == S_IDLE);
    assign w_acc         = i_in.valid && i_in.ready;
    assign o_out.valid   = r_ovalid;
    assign o_out.payload = r_out;
    assign w_last        = ({1'b0, r_idx} == r_n - 1'b1);
    assign w_cnt = (i_in.payload.point_count > CNT_W'(MAX_POINTS)) ?
                   CNT_W'(MAX_POINTS) : i_in.payload.point_count;

    // Shared read address for the per-point memories other than the parent memory.
    assign w_ra = (r_state == S_PRD) ? r_pick : r_idx;

    // Memory write ports.
    always_comb begin
        w_xy_we = w_acc && (i_in.payload.command == CMD_LOAD);
        w_xy_wa = i_in.payload.point_index;
        w_p_we  = 1'b0;
        w_p_wa  = r_idx;
        w_p_wd  = r_idx;
        w_r_we  = 1'b0;
        w_b_we  = 1'b0;
        w_b_wa  = r_idx;
        w_b_wd  = r_w;
        w_t_we  = 1'b0;
        w_t_wa  = r_idx;
        w_t_wd  = 1'b0;
        case (r_state)
            S_CLR: w_p_we = 1'b1;
            S_FEV: begin
                if (w_pd == r_fp) begin
                    if (r_ctx == F_LB && r_ra != r_fp) begin
                        w_p_we = 1'b1;
                        w_p_wa = r_ra;
                        w_p_wd = r_fp;
                    end
                    if (r_ctx == F_INIT) begin
                        w_r_we = 1'b1;
                        w_b_we = 1'b1;
                        w_b_wd = '1;
                        w_t_we = 1'b1;
                    end
                end
            end
            S_P0: begin
                w_t_we = 1'b1;
                w_t_wa = '0;
                w_t_wd = 1'b1;
            end
            S_SPK: begin
                w_t_we = 1'b1;
                w_t_wa = r_pick;
                w_t_wd = 1'b1;
            end
            S_UCMP: w_b_we = (r_w < r_bcur);
            default: ;
        endcase
    end

    emst_ram #(.W(COORD_BITS), .D(MAX_POINTS)) u_x_ram (
        .i_clk(i_clk), .i_we(w_xy_we), .i_wa(w_xy_wa), .i_wd(i_in.payload.point_x),
        .i_ra(w_ra), .o_rd(w_xd)
    );
    emst_ram #(.W(COORD_BITS), .D(MAX_POINTS)) u_y_ram (
        .i_clk(i_clk), .i_we(w_xy_we), .i_wa(w_xy_wa), .i_wd(i_in.payload.point_y),
        .i_ra(w_ra), .o_rd(w_yd)
    );
    emst_ram #(.W(AW), .D(MAX_POINTS)) u_parent_ram (
        .i_clk(i_clk), .i_we(w_p_we), .i_wa(w_p_wa), .i_wd(w_p_wd),
        .i_ra(r_fp), .o_rd(w_pd)
    );
    emst_ram #(.W(AW), .D(MAX_POINTS)) u_root_ram (
        .i_clk(i_clk), .i_we(w_r_we), .i_wa(r_idx), .i_wd(r_fp),
        .i_ra(w_ra), .o_rd(w_rd)
    );
    emst_ram #(.W(BEST_W), .D(MAX_POINTS)) u_best_ram (
        .i_clk(i_clk), .i_we(w_b_we), .i_wa(w_b_wa), .i_wd(w_b_wd),
        .i_ra(w_ra), .o_rd(w_bd)
    );
    emst_ram #(.W(1), .D(MAX_POINTS)) u_tree_ram (
        .i_clk(i_clk), .i_we(w_t_we), .i_wa(w_t_wa), .i_wd(w_t_wd),
        .i_ra(w_ra), .o_rd(w_td)
    );

    // Distance unit, started for points not yet in the tree and outside the group of the new member.
    assign w_dstart = (r_state == S_UEV) && !w_td && (w_rd != r_proot);

    emst_dist u_dist (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_xa(r_px), .i_xb(w_xd), .i_ya(r_py), .i_yb(w_yd),
        .o_done(w_ddone), .o_len(w_dlen)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= '0;
            r_cmp    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == AW'(MAX_POINTS - 1)) begin
                        r_state <= r_cmp ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_in.payload.command)
                            CMD_LINK: begin
                                r_fp    <= i_in.payload.link_end_a;
                                r_lb    <= i_in.payload.link_end_b;
                                r_ctx   <= F_LA;
                                r_state <= S_FRD;
                            end
                            CMD_COMPUTE: begin
                                r_n   <= w_cnt;
                                r_sum <= '0;
                                r_sat <= 1'b0;
                                r_cmp <= 1'b1;
                                r_idx <= '0;
                                r_fp  <= '0;
                                r_ctx <= F_INIT;
                                r_state <= (w_cnt == '0) ? S_CLR : S_FRD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FRD: r_state <= S_FEV;
                S_FEV: begin
                    if (w_pd != r_fp) begin
                        r_fp    <= w_pd;
                        r_state <= S_FRD;
                    end else begin
                        case (r_ctx)
                            F_LA: begin
                                r_ra    <= r_fp;
                                r_fp    <= r_lb;
                                r_ctx   <= F_LB;
                                r_state <= S_FRD;
                            end
                            F_LB: r_state <= S_IDLE;
                            default: begin
                                if (w_last) begin
                                    r_state <= S_P0;
                                end else begin
                                    r_idx   <= r_idx + 1'b1;
                                    r_fp    <= r_idx + 1'b1;
                                    r_state <= S_FRD;
                                end
                            end
                        endcase
                    end
                end
                S_P0: begin
                    r_pick  <= '0;
                    r_k     <= CNT_W'(1);
                    r_state <= S_PRD;
                end
                S_PRD: r_state <= S_PLT;
                S_PLT: begin
                    r_px    <= w_xd;
                    r_py    <= w_yd;
                    r_proot <= w_rd;
                    r_idx   <= '0;
                    r_state <= S_URD;
                end
                S_URD: r_state <= S_UEV;
                S_UEV: begin
                    r_bcur <= w_bd;
                    if (w_td) begin
                        r_w     <= '1;
                        r_state <= S_UCMP;
                    end else if (w_rd == r_proot) begin
                        r_w     <= '0;
                        r_state <= S_UCMP;
                    end else begin
                        r_state <= S_UWT;
                    end
                end
                S_UWT: begin
                    if (w_ddone) begin
                        r_w     <= {1'b0, w_dlen};
                        r_state <= S_UCMP;
                    end
                end
                S_UCMP: begin
                    if (w_last) begin
                        r_idx  <= '0;
                        r_have <= 1'b0;
                        if (r_k == r_n) begin
                            r_state <= S_CLR;
                        end else begin
                            r_state <= S_SRD;
                        end
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_SRD: r_state <= S_SEV;
                S_SEV: begin
                    if (!w_td && (!r_have || w_bd < r_bbest)) begin
                        r_pick  <= r_idx;
                        r_bbest <= w_bd;
                        r_have  <= 1'b1;
                    end
                    if (w_last) begin
                        r_state <= S_SPK;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_SPK: begin
                    if ({{(SUM_W+1-BEST_W){1'b0}}, r_bbest} > {1'b0, SUM_MAX - r_sum}) begin
                        r_sum <= SUM_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_sum <= r_sum + SUM_W'(r_bbest);
                    end
                    r_k     <= r_k + 1'b1;
                    r_state <= S_PRD;
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_out.total_length <= r_sum;
                        r_out.saturated    <= r_sat;
                        r_ovalid           <= 1'b1;
                        r_cmp              <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for the Euclidean spanning tree unit with existing links.
`timescale 1ns / 1ps
module testbench;
    import emst_pkg::*;

    localparam longint CYCLE_LIMIT  = 150_000_000;
    localparam int     ITEM_TARGET  = 650;
    localparam int     TAIL_CYCLES  = 1200;

    logic clk;
    logic rst_n;
    emst_in_if  in_ch ();
    emst_out_if out_ch ();

    euclidean_mst_with_links_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the point stores and the link groups.
    logic [19:0] pt_x [MAX_POINTS];
    logic [19:0] pt_y [MAX_POINTS];
    bit          pt_loaded [MAX_POINTS];
    int          grp_up [MAX_POINTS];
    int          grp_root [MAX_POINTS];
    longint      best_len [MAX_POINTS];
    bit          joined [MAX_POINTS];

    t_out_item totals_due [$];
    int        fail_count;
    int        items_sent;
    longint    cycle_count;
    bit        no_idle;
    int        hold_left;
    int        stall_left;

    // Free-running clock and watchdog.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int find_group(int p);
        int steps;
        for (steps = 0; steps < MAX_POINTS && grp_up[p] != p; steps++) begin
            p = grp_up[p];
        end
        return p;
    endfunction

    // Floor of sqrt(d2) scaled by 2^16, found bit by bit.
    function automatic longint seg_length(int a, int b);
        logic [19:0] dx, dy;
        logic [79:0] val, cand;
        logic [37:0] root;
        dx   = (pt_x[a] > pt_x[b]) ? pt_x[a] - pt_x[b] : pt_x[b] - pt_x[a];
        dy   = (pt_y[a] > pt_y[b]) ? pt_y[a] - pt_y[b] : pt_y[b] - pt_y[a];
        val  = ((80'(dx) * 80'(dx)) + (80'(dy) * 80'(dy))) << 32;
        root = '0;
        for (int bitpos = 37; bitpos >= 0; bitpos--) begin
            cand = 80'(root | (38'd1 << bitpos));
            if (cand * cand <= val) root = root | (38'd1 << bitpos);
        end
        return longint'(root);
    endfunction

    // Prim over the first cnt points; points in one group join at no cost.
    task automatic predict_total(input int cnt);
        int        n, pick;
        longint    w, sum;
        t_out_item res;
        n   = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
        sum = 0;
        res = '0;
        for (int i = 0; i < n; i++) begin
            grp_root[i] = find_group(i);
            joined[i]   = 1'b0;
            best_len[i] = 0;
        end
        if (n > 0) begin
            for (int i = 1; i < n; i++)
                best_len[i] = (grp_root[i] == grp_root[0]) ? 0 : seg_length(0, i);
            joined[0] = 1'b1;
            for (int k = 1; k < n; k++) begin
                pick = n;
                for (int i = 0; i < n; i++)
                    if (!joined[i] && (pick == n || best_len[i] < best_len[pick])) pick = i;
                joined[pick] = 1'b1;
                if (best_len[pick] > longint'(SUM_MAX) - sum) begin
                    sum = longint'(SUM_MAX);
                    res.saturated = 1'b1;
                end else begin
                    sum += best_len[pick];
                end
                for (int i = 0; i < n; i++) begin
                    if (joined[i]) continue;
                    w = (grp_root[i] == grp_root[pick]) ? 0 : seg_length(pick, i);
                    if (w < best_len[i]) best_len[i] = w;
                end
            end
        end
        for (int i = 0; i < MAX_POINTS; i++) grp_up[i] = i;
        res.total_length = sum[46:0];
        totals_due = {totals_due, res};
    endtask

    // Update the shadow state for one accepted item.
    task automatic apply_item(input t_in_item it);
        int ra, rb;
        case (it.command)
            CMD_LOAD: begin
                pt_x[it.point_index]      = it.point_x;
                pt_y[it.point_index]      = it.point_y;
                pt_loaded[it.point_index] = 1'b1;
            end
            CMD_LINK: begin
                ra = find_group(int'(it.link_end_a));
                rb = find_group(int'(it.link_end_b));
                if (ra != rb) grp_up[ra] = rb;
            end
            CMD_COMPUTE: predict_total(int'(it.point_count));
            default: ;
        endcase
    endtask

    // Offer one item after a random gap and wait until it is taken.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        repeat (gap) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid   = 1'b1;
        in_ch.payload = it;
        do @(posedge clk); while (!in_ch.ready);
        apply_item(it);
        if (it.command != CMD_UNUSED) items_sent++;
    endtask

    function automatic t_in_item noise_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_in_item)-1:0];
    endfunction

    task automatic send_load(input int idx, input logic [19:0] x, input logic [19:0] y);
        t_in_item it;
        it             = noise_item();
        it.command     = CMD_LOAD;
        it.point_index = AW'(idx);
        it.point_x     = x;
        it.point_y     = y;
        send_item(it);
    endtask

    task automatic send_link(input int a, input int b);
        t_in_item it;
        it            = noise_item();
        it.command    = CMD_LINK;
        it.link_end_a = AW'(a);
        it.link_end_b = AW'(b);
        send_item(it);
    endtask

    task automatic send_compute(input int cnt);
        t_in_item it;
        it             = noise_item();
        it.command     = CMD_COMPUTE;
        it.point_count = CNT_W'(cnt);
        send_item(it);
    endtask

    // Number of points from index zero that have all been loaded.
    function automatic int loaded_prefix();
        int n;
        n = 0;
        while (n < MAX_POINTS && pt_loaded[n]) n++;
        return n;
    endfunction

    // Result side: stall per item, plus long holds on request.
    always @(negedge clk) begin
        if (rst_n) begin
            if (hold_left > 0) begin
                out_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Compare each result item with the oldest expected total.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 18);
            if (totals_due.size() == 0) begin
                $error("unexpected result item: total_length %0d", out_ch.payload.total_length);
                fail_count++;
            end else begin
                want = totals_due.pop_front();
                if (out_ch.payload.total_length !== want.total_length) begin
                    $error("total_length: expected %0d, got %0d",
                           want.total_length, out_ch.payload.total_length);
                    fail_count++;
                end
                if (out_ch.payload.saturated !== want.saturated) begin
                    $error("saturated: expected %0d, got %0d",
                           want.saturated, out_ch.payload.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Extremes of the coordinates, links of every kind and the odd counts.
    task automatic test_directed();
        t_in_item it;
        send_load(0, 20'h00000, 20'h00000);
        send_load(1, 20'hFFFFF, 20'hFFFFF);
        send_load(2, 20'h00000, 20'hFFFFF);
        send_load(3, 20'hFFFFF, 20'h00000);
        send_load(4, 20'hFFFFF, 20'hFFFFF);
        for (int i = 5; i < 16; i++) send_load(i, 20'($urandom), 20'($urandom));
        send_compute(0);
        send_compute(1);
        send_compute(5);
        // A self link, a repeated link and a link beyond the count.
        send_link(2, 2);
        send_link(0, 1);
        send_link(1, 0);
        send_link(3, 1000);
        send_link(1000, 2);
        // An unknown command must leave the state alone.
        it         = noise_item();
        it.command = CMD_UNUSED;
        send_item(it);
        send_compute(16);
    endtask

    // Scenarios of loads and links closed by a compute, mixed with noise.
    task automatic test_random();
        int cnt, top, links;
        t_in_item it;
        while (items_sent < ITEM_TARGET - 40) begin
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 6)) begin
                if ($urandom_range(0, 5) == 0)
                    send_load($urandom_range(0, 1023), 20'($urandom), 20'($urandom));
                else
                    send_load($urandom_range(0, 31), 20'($urandom), 20'($urandom));
            end
            links = $urandom_range(0, 5);
            repeat (links) begin
                if ($urandom_range(0, 4) == 0) send_link($urandom_range(0, 1023), $urandom_range(0, 1023));
                else send_link($urandom_range(0, 15), $urandom_range(0, 15));
            end
            if ($urandom_range(0, 7) == 0) begin
                it         = noise_item();
                it.command = CMD_UNUSED;
                send_item(it);
            end
            top = loaded_prefix();
            cnt = ($urandom_range(0, 11) == 0) ? 48 : $urandom_range(0, 20);
            if (cnt > top) cnt = top;
            send_compute(cnt);
        end
        no_idle = 1'b0;
    endtask

    // Hold the result side off while items keep coming, then drain fully.
    task automatic test_backpressure();
        @(posedge clk);
        hold_left = 40000;
        send_compute(12);
        for (int i = 0; i < 8; i++) send_load(i, 20'($urandom), 20'($urandom));
        send_link(0, 7);
        send_compute(10);
        // The second total cannot leave, so this load waits at the input.
        send_load(8, 20'($urandom), 20'($urandom));
        @(negedge clk);
        in_ch.valid = 1'b0;
        wait (totals_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        send_link(3, 4);
        send_compute(9);
    endtask

    initial begin
        rst_n          = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        fail_count     = 0;
        items_sent     = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;
        hold_left      = 0;
        stall_left     = 0;
        for (int i = 0; i < MAX_POINTS; i++) begin
            grp_up[i]    = i;
            pt_loaded[i] = 1'b0;
            pt_x[i]      = '0;
            pt_y[i]      = '0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random();
        test_backpressure();

        @(negedge clk);
        in_ch.valid = 1'b0;
        wait (totals_due.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
